FILE: rtl/core/erv_pkg.sv
// shared types, constants and the quarter-wave sine table builder for the
// euler rotate vector block; no dependencies
`default_nettype none

package erv_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;            // must be a power of two
   localparam int TBL_BITS         = $clog2(SINE_TABLE_DEPTH);
   localparam int IDX_W            = TBL_BITS + 1;    // index runs 0..depth
   localparam int ANGLE_W          = 16;
   localparam int ENTRY_W          = 15;
   localparam int TRIG_W           = 17;
   localparam int VEC_W            = 32;
   localparam int QUEUE_DEPTH      = 2;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

   typedef logic [ENTRY_W-1:0] sine_rom_type [SINE_TABLE_DEPTH+1];

   typedef struct packed {
      logic signed [VEC_W-1:0] fx;
      logic signed [VEC_W-1:0] fy;
      logic signed [VEC_W-1:0] fz;
   } vec_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sr;
      logic signed [TRIG_W-1:0] cr;
      logic signed [TRIG_W-1:0] sp;
      logic signed [TRIG_W-1:0] cp;
      logic signed [TRIG_W-1:0] sy;
      logic signed [TRIG_W-1:0] cy;
      vec_type                  vec;
   } trig_item_type;

   // taylor series in q2.30, evaluated at elaboration only
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type      rom;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint signed     sum;
      longint signed     r;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            term = (term * x2) >> 30;
            // divide by (2k)(2k+1)
            case (k)
               1: term = term / 64'd6;
               2: term = term / 64'd20;
               3: term = term / 64'd42;
               4: term = term / 64'd72;
               5: term = term / 64'd110;
               6: term = term / 64'd156;
               default: term = term / 64'd210;
            endcase
            if (k % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         r = (sum + 64'sd16384) >>> 15;
         if (r > 64'sd32767) begin
            r = 64'sd32767;
         end
         if (r < 64'sd0) begin
            r = 64'sd0;
         end
         rom[i] = r[ENTRY_W-1:0];
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/erv_trig.sv
// sine and cosine of one angle: quadrant fold, then a registered rom read
// depends on erv_pkg
`default_nettype none

module erv_trig (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic [erv_pkg::ANGLE_W-1:0]       angle,
   output logic signed [erv_pkg::TRIG_W-1:0]      sin_val,
   output logic signed [erv_pkg::TRIG_W-1:0]      cos_val
);

   localparam erv_pkg::sine_rom_type SINE_ROM = erv_pkg::build_sine_rom();
   localparam int PB = erv_pkg::TBL_BITS + 2;

   logic [erv_pkg::ANGLE_W-1:0] cos_angle;
   logic [erv_pkg::IDX_W-1:0]   sin_idx_in, cos_idx_in;
   logic                        sin_neg_in, cos_neg_in;
   logic [erv_pkg::IDX_W-1:0]   sin_idx_ff, cos_idx_ff;
   logic                        sin_neg_ff, cos_neg_ff;
   logic                        sin_neg2_ff, cos_neg2_ff;
   logic [erv_pkg::ENTRY_W-1:0] sin_rom_ff, cos_rom_ff;

   function automatic logic [erv_pkg::IDX_W-1:0] fold_idx(logic [erv_pkg::ANGLE_W-1:0] a);
      logic [PB-1:0]                  p;
      logic [erv_pkg::IDX_W-1:0]      r;
      p = a[erv_pkg::ANGLE_W-1 -: PB];
      r = {1'b0, p[erv_pkg::TBL_BITS-1:0]};
      if (p[erv_pkg::TBL_BITS]) begin
         return erv_pkg::IDX_W'(erv_pkg::SINE_TABLE_DEPTH) - r;
      end
      return r;
   endfunction

   assign cos_angle  = angle + erv_pkg::QUARTER_TURN;
   assign sin_idx_in = fold_idx(angle);
   assign cos_idx_in = fold_idx(cos_angle);
   assign sin_neg_in = angle[erv_pkg::ANGLE_W-1];
   assign cos_neg_in = cos_angle[erv_pkg::ANGLE_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         sin_idx_ff  <= sin_idx_in;
         cos_idx_ff  <= cos_idx_in;
         sin_neg_ff  <= sin_neg_in;
         cos_neg_ff  <= cos_neg_in;
         sin_rom_ff  <= SINE_ROM[sin_idx_ff];
         cos_rom_ff  <= SINE_ROM[cos_idx_ff];
         sin_neg2_ff <= sin_neg_ff;
         cos_neg2_ff <= cos_neg_ff;
      end
   end

   assign sin_val = sin_neg2_ff ? -$signed({2'b00, sin_rom_ff}) : $signed({2'b00, sin_rom_ff});
   assign cos_val = cos_neg2_ff ? -$signed({2'b00, cos_rom_ff}) : $signed({2'b00, cos_rom_ff});

endmodule

`default_nettype wire

FILE: rtl/core/erv_front.sv
// front end: accepts transactions, looks up sine and cosine of all three angles
// depends on erv_pkg, erv_trig
`default_nettype none

module erv_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [erv_pkg::ANGLE_W-1:0]   req_roll_angle,
   input  wire logic [erv_pkg::ANGLE_W-1:0]   req_pitch_angle,
   input  wire logic [erv_pkg::ANGLE_W-1:0]   req_yaw_angle,
   input  wire erv_pkg::vec_type              req_vec,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output erv_pkg::trig_item_type             out_item
);

   logic             en;
   logic             v1_ff, v2_ff;
   erv_pkg::vec_type vec1_ff, vec2_ff;

   assign en        = !v2_ff || out_ready;
   assign req_ready = en;
   assign out_valid = v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec1_ff <= req_vec;
         vec2_ff <= vec1_ff;
      end
   end

   erv_trig u_roll  (.clock(clock), .en(en), .angle(req_roll_angle),
                     .sin_val(out_item.sr), .cos_val(out_item.cr));
   erv_trig u_pitch (.clock(clock), .en(en), .angle(req_pitch_angle),
                     .sin_val(out_item.sp), .cos_val(out_item.cp));
   erv_trig u_yaw   (.clock(clock), .en(en), .angle(req_yaw_angle),
                     .sin_val(out_item.sy), .cos_val(out_item.cy));

   assign out_item.vec = vec2_ff;

endmodule

`default_nettype wire

FILE: rtl/core/erv_queue.sv
// short fifo between front and back end
// depends on erv_pkg
`default_nettype none

module erv_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire erv_pkg::trig_item_type in_item,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output erv_pkg::trig_item_type      out_item
);

   localparam int PW = $clog2(erv_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(erv_pkg::QUEUE_DEPTH + 1);

   erv_pkg::trig_item_type entry_ff [erv_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          push, pop;

   assign in_ready  = count_ff != CW'(erv_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/erv_back.sv
// back end: builds the rotation matrix and multiplies the vector, then rounds
// and saturates; depends on erv_pkg
`default_nettype none

module erv_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire erv_pkg::trig_item_type        in_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [erv_pkg::VEC_W-1:0]   rsp_dir_x,
   output logic signed [erv_pkg::VEC_W-1:0]   rsp_dir_y,
   output logic signed [erv_pkg::VEC_W-1:0]   rsp_dir_z,
   output logic                               rsp_saturated
);

   localparam int TW = erv_pkg::TRIG_W;
   localparam int PW = 2 * TW;      // q1.15 times q1.15
   localparam int SW = PW + 1;
   localparam int MW = SW - 15;     // matrix entry after rounding
   localparam int FW = erv_pkg::VEC_W + MW;
   localparam int AW = FW + 2;
   localparam int RW = AW - 15;
   localparam int NS = 7;

   typedef struct packed {
      logic signed [PW-1:0] srsp, crsp, cpcy, cpsy, srcp, crcp, crsy, crcy, srsy, srcy;
      logic signed [TW-1:0] sp, sy, cy;
      erv_pkg::vec_type     vec;
   } s1_type;

   typedef struct packed {
      logic signed [TW-1:0] srsp, crsp, sy, cy;
      logic signed [MW-1:0] m0, m1, m2, m5, m8;
      logic signed [PW-1:0] crsy, crcy, srsy, srcy;
      erv_pkg::vec_type     vec;
   } s2_type;

   typedef struct packed {
      logic signed [PW-1:0] q1, q2, q3, q4, crsy, crcy, srsy, srcy;
      logic signed [MW-1:0] m0, m1, m2, m5, m8;
      erv_pkg::vec_type     vec;
   } s3_type;

   typedef struct packed {
      logic signed [MW-1:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;
      erv_pkg::vec_type     vec;
   } s4_type;

   typedef struct packed {
      logic signed [FW-1:0] p0, p1, p2, p3, p4, p5, p6, p7, p8;
   } s5_type;

   typedef struct packed {
      logic signed [AW-1:0] ax, ay, az;
   } s6_type;

   typedef struct packed {
      logic signed [erv_pkg::VEC_W-1:0] dx, dy, dz;
      logic                             sat;
   } s7_type;

   logic          en;
   logic [NS-1:0] valid_ff;
   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   s6_type s6_in, s6_ff;
   s7_type s7_in, s7_ff;

   // round half up by 15 bits
   function automatic logic signed [MW-1:0] rnd15(logic signed [SW-1:0] v);
      logic signed [SW-1:0] t;
      t = v + SW'(16384);
      return MW'(t >>> 15);
   endfunction

   function automatic logic signed [erv_pkg::VEC_W-1:0] clamp(logic signed [RW-1:0] v);
      if (v > RW'(64'sd2147483647)) return 32'sh7fffffff;
      if (v < -RW'(64'sd2147483648)) return 32'sh80000000;
      return v[erv_pkg::VEC_W-1:0];
   endfunction

   function automatic logic clamped(logic signed [RW-1:0] v);
      return (v > RW'(64'sd2147483647)) || (v < -RW'(64'sd2147483648));
   endfunction

   assign en       = !valid_ff[NS-1] || rsp_ready;
   assign in_ready = en;

   always_comb begin
      s1_in.srsp = in_item.sr * in_item.sp;
      s1_in.crsp = in_item.cr * in_item.sp;
      s1_in.cpcy = in_item.cp * in_item.cy;
      s1_in.cpsy = in_item.cp * in_item.sy;
      s1_in.srcp = in_item.sr * in_item.cp;
      s1_in.crcp = in_item.cr * in_item.cp;
      s1_in.crsy = in_item.cr * in_item.sy;
      s1_in.crcy = in_item.cr * in_item.cy;
      s1_in.srsy = in_item.sr * in_item.sy;
      s1_in.srcy = in_item.sr * in_item.cy;
      s1_in.sp   = in_item.sp;
      s1_in.sy   = in_item.sy;
      s1_in.cy   = in_item.cy;
      s1_in.vec  = in_item.vec;
   end

   always_comb begin
      s2_in.srsp = TW'(rnd15(SW'(s1_ff.srsp)));
      s2_in.crsp = TW'(rnd15(SW'(s1_ff.crsp)));
      s2_in.sy   = s1_ff.sy;
      s2_in.cy   = s1_ff.cy;
      s2_in.m0   = rnd15(SW'(s1_ff.cpcy));
      s2_in.m1   = rnd15(SW'(s1_ff.cpsy));
      s2_in.m2   = -MW'(s1_ff.sp);    // the lone sine term rounds back exactly
      s2_in.m5   = rnd15(SW'(s1_ff.srcp));
      s2_in.m8   = rnd15(SW'(s1_ff.crcp));
      s2_in.crsy = s1_ff.crsy;
      s2_in.crcy = s1_ff.crcy;
      s2_in.srsy = s1_ff.srsy;
      s2_in.srcy = s1_ff.srcy;
      s2_in.vec  = s1_ff.vec;
   end

   always_comb begin
      s3_in.q1   = s2_ff.srsp * s2_ff.cy;
      s3_in.q2   = s2_ff.srsp * s2_ff.sy;
      s3_in.q3   = s2_ff.crsp * s2_ff.cy;
      s3_in.q4   = s2_ff.crsp * s2_ff.sy;
      s3_in.crsy = s2_ff.crsy;
      s3_in.crcy = s2_ff.crcy;
      s3_in.srsy = s2_ff.srsy;
      s3_in.srcy = s2_ff.srcy;
      s3_in.m0   = s2_ff.m0;
      s3_in.m1   = s2_ff.m1;
      s3_in.m2   = s2_ff.m2;
      s3_in.m5   = s2_ff.m5;
      s3_in.m8   = s2_ff.m8;
      s3_in.vec  = s2_ff.vec;
   end

   always_comb begin
      s4_in.m0  = s3_ff.m0;
      s4_in.m1  = s3_ff.m1;
      s4_in.m2  = s3_ff.m2;
      s4_in.m3  = rnd15(SW'(s3_ff.q1) - SW'(s3_ff.crsy));
      s4_in.m4  = rnd15(SW'(s3_ff.q2) + SW'(s3_ff.crcy));
      s4_in.m5  = s3_ff.m5;
      s4_in.m6  = rnd15(SW'(s3_ff.q3) + SW'(s3_ff.srsy));
      s4_in.m7  = rnd15(SW'(s3_ff.q4) - SW'(s3_ff.srcy));
      s4_in.m8  = s3_ff.m8;
      s4_in.vec = s3_ff.vec;
   end

   always_comb begin
      s5_in.p0 = s4_ff.vec.fx * s4_ff.m0;
      s5_in.p3 = s4_ff.vec.fy * s4_ff.m3;
      s5_in.p6 = s4_ff.vec.fz * s4_ff.m6;
      s5_in.p1 = s4_ff.vec.fx * s4_ff.m1;
      s5_in.p4 = s4_ff.vec.fy * s4_ff.m4;
      s5_in.p7 = s4_ff.vec.fz * s4_ff.m7;
      s5_in.p2 = s4_ff.vec.fx * s4_ff.m2;
      s5_in.p5 = s4_ff.vec.fy * s4_ff.m5;
      s5_in.p8 = s4_ff.vec.fz * s4_ff.m8;
   end

   always_comb begin
      s6_in.ax = AW'(s5_ff.p0) + AW'(s5_ff.p3) + AW'(s5_ff.p6) + AW'(16384);
      s6_in.ay = AW'(s5_ff.p1) + AW'(s5_ff.p4) + AW'(s5_ff.p7) + AW'(16384);
      s6_in.az = AW'(s5_ff.p2) + AW'(s5_ff.p5) + AW'(s5_ff.p8) + AW'(16384);
   end

   always_comb begin
      s7_in.dx  = clamp(RW'(s6_ff.ax >>> 15));
      s7_in.dy  = clamp(RW'(s6_ff.ay >>> 15));
      s7_in.dz  = clamp(RW'(s6_ff.az >>> 15));
      s7_in.sat = clamped(RW'(s6_ff.ax >>> 15)) || clamped(RW'(s6_ff.ay >>> 15))
                  || clamped(RW'(s6_ff.az >>> 15));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

   assign rsp_valid     = valid_ff[NS-1];
   assign rsp_dir_x     = s7_ff.dx;
   assign rsp_dir_y     = s7_ff.dy;
   assign rsp_dir_z     = s7_ff.dz;
   assign rsp_saturated = s7_ff.sat;

endmodule

`default_nettype wire

FILE: rtl/core/euler_rotate_vector_top.sv
// top level of the euler rotate vector block
// depends on erv_pkg, erv_front, erv_queue, erv_back
//
// Rotates a signed Q16.16 forward vector by roll, pitch and yaw (65536 units
// per turn) and returns the rounded, saturated result with a clamp flag. One
// transaction is taken every clock cycle while the result side keeps up; on its
// way to the result a transaction passes the index and rom registers of the
// sine table lookup in the front end, an entry of the queue and seven stages
// of registered multiplies, sums and saturation in the back end. The two
// halves stall independently across a two-entry queue.
`default_nettype none

module euler_rotate_vector_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [15:0]          req_roll_angle,
   input  wire logic [15:0]          req_pitch_angle,
   input  wire logic [15:0]          req_yaw_angle,
   input  wire logic signed [31:0]   req_forward_x,
   input  wire logic signed [31:0]   req_forward_y,
   input  wire logic signed [31:0]   req_forward_z,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [31:0]        rsp_dir_x,
   output logic signed [31:0]        rsp_dir_y,
   output logic signed [31:0]        rsp_dir_z,
   output logic                      rsp_saturated
);

   erv_pkg::vec_type       req_vec;
   erv_pkg::trig_item_type front_item, back_item;
   logic                   front_valid, front_ready;
   logic                   back_valid, back_ready;

   assign req_vec.fx = req_forward_x;
   assign req_vec.fy = req_forward_y;
   assign req_vec.fz = req_forward_z;

   erv_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_roll_angle(req_roll_angle), .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle(req_yaw_angle), .req_vec(req_vec),
      .out_valid(front_valid), .out_ready(front_ready), .out_item(front_item)
   );

   erv_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(front_valid), .in_ready(front_ready), .in_item(front_item),
      .out_valid(back_valid), .out_ready(back_ready), .out_item(back_item)
   );

   erv_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(back_valid), .in_ready(back_ready), .in_item(back_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_dir_x(rsp_dir_x), .rsp_dir_y(rsp_dir_y), .rsp_dir_z(rsp_dir_z),
      .rsp_saturated(rsp_saturated)
   );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for euler_rotate_vector_top: random and directed
// rotations checked against an in-bench fixed-point predictor; uses erv_pkg
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic [15:0]        roll, pitch, yaw;
      logic signed [31:0] fx, fy, fz;
      bit                 drain_first;
   } rot_req_type;

   typedef struct {
      logic signed [31:0] dx, dy, dz;
      logic               sat;
   } rot_dir_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [15:0]        req_roll_angle = '0, req_pitch_angle = '0, req_yaw_angle = '0;
   logic signed [31:0] req_forward_x = '0, req_forward_y = '0, req_forward_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic               rsp_saturated;

   rot_req_type pending_q[$];
   rot_dir_type expected_dirs[$];
   rot_req_type cur_req;
   longint      quarter_sine [erv_pkg::SINE_TABLE_DEPTH+1];
   int          n_sent = 0, n_checked = 0, n_sat = 0, errors = 0;
   int          send_idle = 0, recv_idle = 0, hold_cycles = 0;
   bit          hold_done = 0;

   euler_rotate_vector_top uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // quarter-wave table, taylor series in q2.30
   function automatic longint sine_entry(int i);
      longint unsigned x, x2, term;
      longint          sum, r;
      x = (erv_pkg::HALF_PI_Q30 * longint'(i)) / erv_pkg::SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      r = (sum + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < 0) r = 0;
      return r;
   endfunction

   function automatic longint bam_sine(logic [15:0] a);
      int p, q, r;
      longint v;
      p = int'(a) >> 4;
      q = (p / erv_pkg::SINE_TABLE_DEPTH) & 3;
      r = p % erv_pkg::SINE_TABLE_DEPTH;
      v = (q & 1) ? quarter_sine[erv_pkg::SINE_TABLE_DEPTH - r] : quarter_sine[r];
      return (q & 2) ? -v : v;
   endfunction

   function automatic longint rnd15(longint v);
      return (v + 16384) >>> 15;
   endfunction

   function automatic logic signed [31:0] clamp32(longint acc, ref logic sat);
      longint v;
      v = rnd15(acc);
      if (v > 64'sd2147483647) begin
         v = 64'sd2147483647;
         sat = 1'b1;
      end else if (v < -64'sd2147483648) begin
         v = -64'sd2147483648;
         sat = 1'b1;
      end
      return v[31:0];
   endfunction

   function automatic rot_dir_type rotate_vector(rot_req_type t);
      longint sr, cr, sp, cp, sy, cy, fx, fy, fz, srsp, crsp;
      longint m [9];
      rot_dir_type d;
      sr = bam_sine(t.roll);
      cr = bam_sine(t.roll + erv_pkg::QUARTER_TURN);
      sp = bam_sine(t.pitch);
      cp = bam_sine(t.pitch + erv_pkg::QUARTER_TURN);
      sy = bam_sine(t.yaw);
      cy = bam_sine(t.yaw + erv_pkg::QUARTER_TURN);
      fx = t.fx; fy = t.fy; fz = t.fz;
      srsp = rnd15(sr * sp);
      crsp = rnd15(cr * sp);
      m[0] = rnd15(cp * cy);
      m[1] = rnd15(cp * sy);
      m[2] = rnd15(-(sp * 32768));
      m[3] = rnd15(srsp * cy - cr * sy);
      m[4] = rnd15(srsp * sy + cr * cy);
      m[5] = rnd15(sr * cp);
      m[6] = rnd15(crsp * cy + sr * sy);
      m[7] = rnd15(crsp * sy - sr * cy);
      m[8] = rnd15(cr * cp);
      d.sat = 1'b0;
      d.dx = clamp32(fx * m[0] + fy * m[3] + fz * m[6], d.sat);
      d.dy = clamp32(fx * m[1] + fy * m[4] + fz * m[7], d.sat);
      d.dz = clamp32(fx * m[2] + fy * m[5] + fz * m[8], d.sat);
      return d;
   endfunction

   function automatic logic signed [31:0] rand_comp();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         1: return $signed(32'($urandom_range(0, 1 << 20))) - (1 <<< 19);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_req(logic [15:0] r, p, y, logic signed [31:0] x, yv, z, bit drain);
      rot_req_type t;
      t.roll = r; t.pitch = p; t.yaw = y;
      t.fx = x; t.fy = yv; t.fz = z;
      t.drain_first = drain;
      pending_q.push_back(t);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_dirs.push_back(rotate_vector(cur_req));
            n_sent <= n_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_idle > 0) begin
               send_idle <= send_idle - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 80 && $urandom_range(0, 9) == 0) begin
               send_idle <= $urandom_range(1, 18) - 1;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0 &&
                         (!pending_q[0].drain_first ||
                          (expected_dirs.size() == 0 && !req_valid))) begin
               cur_req = pending_q.pop_front();
               req_roll_angle <= cur_req.roll;
               req_pitch_angle <= cur_req.pitch;
               req_yaw_angle <= cur_req.yaw;
               req_forward_x <= cur_req.fx;
               req_forward_y <= cur_req.fy;
               req_forward_z <= cur_req.fz;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, with one long hold to fill the pipeline
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && n_sent >= 250) begin
         hold_done <= 1'b1;
         hold_cycles <= 400;
         rsp_ready <= 1'b0;
      end else if (recv_idle > 0) begin
         recv_idle <= recv_idle - 1;
         rsp_ready <= 1'b0;
      end else if (pending_q.size() > 80 && $urandom_range(0, 9) == 0) begin
         recv_idle <= $urandom_range(1, 18) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rot_dir_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_dirs.size() == 0) begin
            $display("%0t: result with no transaction outstanding", $time);
            errors++;
         end else begin
            e = expected_dirs.pop_front();
            if (rsp_dir_x !== e.dx) begin
               $display("%0t: dir_x expected %0d actual %0d", $time, e.dx, rsp_dir_x);
               errors++;
            end
            if (rsp_dir_y !== e.dy) begin
               $display("%0t: dir_y expected %0d actual %0d", $time, e.dy, rsp_dir_y);
               errors++;
            end
            if (rsp_dir_z !== e.dz) begin
               $display("%0t: dir_z expected %0d actual %0d", $time, e.dz, rsp_dir_z);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $display("%0t: saturated expected %0b actual %0b", $time, e.sat,
                        rsp_saturated);
               errors++;
            end
            if (e.sat) n_sat++;
            n_checked++;
         end
      end
   end

   initial begin
      #(8 * 400000);
      $display("FAILURE");
      $finish;
   end

   initial begin
      for (int i = 0; i <= erv_pkg::SINE_TABLE_DEPTH; i++) quarter_sine[i] = sine_entry(i);
      // directed: quadrant boundaries, extreme angles and vectors, clamping
      add_req(16'h0000, 16'h0000, 16'h0000, 32'sh00010000, 32'sh00020000, 32'sh00030000, 0);
      add_req(16'hffff, 16'hffff, 16'hffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
      add_req(16'h4000, 16'h0000, 16'h0000, 32'sh00010000, 32'sh00010000, 32'sh00010000, 0);
      add_req(16'h0000, 16'h4000, 16'h0000, 32'sh80000000, 32'sh00000000, 32'sh00010000, 0);
      add_req(16'h0000, 16'h0000, 16'h4000, 32'sh00010000, 32'sh80000000, 32'sh00000000, 0);
      add_req(16'h8000, 16'h8000, 16'h8000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
      add_req(16'hc000, 16'hc000, 16'hc000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
      add_req(16'h2000, 16'h2000, 16'h2000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
      add_req(16'he000, 16'h6000, 16'ha000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
      add_req(16'h3fff, 16'h4001, 16'hbfff, 32'shffffffff, 32'sh00000001, 32'sh00000000, 0);
      add_req(16'h000f, 16'h0010, 16'hfff0, 32'sh40000000, 32'shc0000000, 32'sh12345678, 0);
      add_req(16'h7fff, 16'h8001, 16'h0001, 32'sh00000000, 32'sh00000000, 32'sh00000000, 0);
      add_req(16'h1555, 16'haaaa, 16'h5555, 32'shaaaaaaaa, 32'sh55555555, 32'shffff0000, 1);
      for (int i = 0; i < 700; i++) begin
         add_req($urandom, $urandom, $urandom, rand_comp(), rand_comp(), rand_comp(),
                 i == 450);
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      while (expected_dirs.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("sent %0d rotations, checked %0d results, %0d of them clamped",
               n_sent, n_checked, n_sat);
      if (errors == 0 && expected_dirs.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
